[rtl/bfba_pkg.sv]
package bfba_pkg;

    localparam int ARENA_BYTES_DEF = 16384;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF = 64;

    localparam int FIELD_W = 15;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    // Broadcast operation applied by every cell in the same cycle
    typedef enum logic [2:0] {
        OP_NOP,
        OP_TAKE,
        OP_SPLIT,
        OP_MARK,
        OP_MERGE
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_MERGE,
        ST_DONE
    } state_t;

endpackage

[rtl/bfba_cell.sv]
module bfba_cell
    import bfba_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int LW = 15,
    parameter int IW = 6,
    parameter type tok_t = logic,
    parameter type op_t = logic
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  op_t           op,
    input  tok_t          tok_in,
    output tok_t          tok_out,
    input  logic [LW-1:0] start_l,
    input  logic [LW-1:0] len_l,
    input  logic          use_l,
    input  logic [LW-1:0] start_r,
    input  logic [LW-1:0] len_r,
    input  logic          use_r,
    output logic [LW-1:0] start_o,
    output logic [LW-1:0] len_o,
    output logic          use_o
);

    localparam logic [IW-1:0] IDX = IW'(INDEX);
    localparam logic [LW-1:0] HDR = LW'(HEADER_BYTES);

    logic [LW-1:0] start_reg, start_next;
    logic [LW-1:0] len_reg, len_next;
    logic          use_reg, use_next;
    tok_t          tok_reg, tok_next;
    logic          valid;
    logic          is_free;
    logic          at_k;
    logic          above_k;
    logic          next_to_k;

    assign valid = ($bits(op.count)'(INDEX) < op.count);
    assign is_free = valid && !use_reg;
    assign at_k = (IDX == op.idx);
    assign above_k = (IDX > op.idx);
    assign next_to_k = above_k && ((IDX - 1'b1) == op.idx);

    // Scan token: best fit and offset match, one cell per cycle
    always_comb begin
        tok_next = tok_in;
        if (is_free && len_reg >= op.size && (!tok_in.found || tok_in.best_len > len_reg)) begin
            tok_next.found = 1'b1;
            tok_next.best_len = len_reg;
            tok_next.best_idx = IDX;
            tok_next.best_start = start_reg;
        end
        if (valid && !tok_in.mfound && start_reg == op.off) begin
            tok_next.mfound = 1'b1;
            tok_next.midx = IDX;
            tok_next.mlen = len_reg;
            tok_next.muse = use_reg;
            tok_next.lf = tok_in.prev_free;
            tok_next.grab = 1'b1;
        end else if (tok_in.grab) begin
            tok_next.rf = is_free;
            tok_next.grab = 1'b0;
        end
        tok_next.prev_free = is_free;
    end

    always_comb begin
        start_next = start_reg;
        len_next = len_reg;
        use_next = use_reg;
        case (op.code)
            OP_TAKE: begin
                if (at_k) use_next = 1'b1;
            end
            OP_SPLIT: begin
                if (at_k) begin
                    len_next = op.size;
                    use_next = 1'b1;
                end else if (next_to_k) begin
                    start_next = start_l + op.size + HDR;
                    len_next = len_l - op.size - HDR;
                    use_next = 1'b0;
                end else if (above_k) begin
                    start_next = start_l;
                    len_next = len_l;
                    use_next = use_l;
                end
            end
            OP_MARK: begin
                if (at_k) use_next = 1'b0;
            end
            OP_MERGE: begin
                if (at_k) begin
                    len_next = len_reg + HDR + len_r;
                    use_next = 1'b0;
                end else if (above_k) begin
                    start_next = start_r;
                    len_next = len_r;
                    use_next = use_r;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= (INDEX == 0) ? HDR : '0;
            len_reg <= (INDEX == 0) ? LW'(ARENA_BYTES - HEADER_BYTES) : '0;
            use_reg <= 1'b0;
            tok_reg <= '0;
        end else begin
            start_reg <= start_next;
            len_reg <= len_next;
            use_reg <= use_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign start_o = start_reg;
    assign len_o = len_reg;
    assign use_o = use_reg;

endmodule

[rtl/best_fit_block_allocator.sv]
// Best-fit block allocator over a byte arena of ARENA_BYTES, kept as an
// address-ordered table of up to MAX_BLOCKS blocks, each preceded by a
// HEADER_BYTES header. One request word on s_ (allocate or free) gives one
// result word on m_: a scan token walks the row of table cells one cell
// per cycle, then an apply step (take, split, mark or merge) updates the
// row in place, a free whose left neighbor is free adds a second merge
// step, and the result is loaded once the result side can take it.
// Requests are taken one at a time; a new word is accepted once the
// previous result is loaded, so a result side that stalls a waiting
// result also holds off the next request.
module best_fit_block_allocator
    import bfba_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes[14:0], release_offset[29:15], zero
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_offset[14:0], free_bytes[29:15], zero
    output logic [1:0]  m_tuser    // status
);

    localparam int AB_W = $clog2(ARENA_BYTES + 1);
    localparam int LW = (AB_W > FIELD_W) ? AB_W : FIELD_W;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LW-1:0] HDR = LW'(HEADER_BYTES);

    typedef struct packed {
        logic          found;
        logic [LW-1:0] best_len;
        logic [IW-1:0] best_idx;
        logic [LW-1:0] best_start;
        logic          mfound;
        logic [IW-1:0] midx;
        logic [LW-1:0] mlen;
        logic          muse;
        logic          lf;
        logic          rf;
        logic          grab;
        logic          prev_free;
    } tok_t;

    typedef struct packed {
        cell_op_t      code;
        logic [IW-1:0] idx;
        logic [LW-1:0] size;
        logic [LW-1:0] off;
        logic [CW-1:0] count;
    } op_t;

    state_t state_reg, state_next;
    logic [IW-1:0] cnt_reg;
    logic [CW-1:0] count_reg;
    logic [LW-1:0] total_reg;
    logic          cmd_reg;
    logic [FIELD_W-1:0] size_reg;
    logic [FIELD_W-1:0] off_reg;
    logic [IW-1:0] k_reg;
    logic          lf_reg;
    logic [1:0]    res_status_reg;
    logic [FIELD_W-1:0] res_off_reg;
    logic          m_tvalid_reg;
    logic [1:0]    m_status_reg;
    logic [FIELD_W-1:0] m_off_reg;
    logic [FIELD_W-1:0] m_free_reg;

    op_t  op;
    tok_t tok_w [MAX_BLOCKS];
    tok_t tok;
    logic [LW-1:0] start_w [MAX_BLOCKS];
    logic [LW-1:0] len_w [MAX_BLOCKS];
    logic          use_w [MAX_BLOCKS];

    logic [LW-1:0] size_ext;
    logic [LW-1:0] rem;
    logic          alloc_ok;
    logic          do_split;
    logic          out_free;

    assign tok = tok_w[MAX_BLOCKS-1];
    assign size_ext = LW'(size_reg);
    assign rem = tok.best_len - size_ext;
    assign alloc_ok = tok.found && !(size_ext > total_reg);
    assign do_split = (rem > HDR) && (count_reg < CW'(MAX_BLOCKS));
    assign out_free = !m_tvalid_reg || m_tready;

    // Row of table cells, each handing its entry and the scan token on
    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            tok_t          t_in;
            logic [LW-1:0] sl, ll, sr, lr;
            logic          ul, ur;
            if (g == 0) begin : g_first
                assign t_in = '0;
                assign sl = '0;
                assign ll = '0;
                assign ul = 1'b0;
            end else begin : g_mid
                assign t_in = tok_w[g-1];
                assign sl = start_w[g-1];
                assign ll = len_w[g-1];
                assign ul = use_w[g-1];
            end
            if (g == MAX_BLOCKS - 1) begin : g_last
                assign sr = '0;
                assign lr = '0;
                assign ur = 1'b0;
            end else begin : g_inner
                assign sr = start_w[g+1];
                assign lr = len_w[g+1];
                assign ur = use_w[g+1];
            end
            bfba_cell #(
                .INDEX(g),
                .ARENA_BYTES(ARENA_BYTES),
                .HEADER_BYTES(HEADER_BYTES),
                .LW(LW),
                .IW(IW),
                .tok_t(tok_t),
                .op_t(op_t)
            ) u_cell (
                .aclk(aclk),
                .aresetn(aresetn),
                .op(op),
                .tok_in(t_in),
                .tok_out(tok_w[g]),
                .start_l(sl),
                .len_l(ll),
                .use_l(ul),
                .start_r(sr),
                .len_r(lr),
                .use_r(ur),
                .start_o(start_w[g]),
                .len_o(len_w[g]),
                .use_o(use_w[g])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:  if (cnt_reg == IW'(MAX_BLOCKS - 1)) state_next = ST_APPLY;
            ST_APPLY: begin
                if (cmd_reg == CMD_FREE && tok.mfound && tok.lf) state_next = ST_MERGE;
                else state_next = ST_DONE;
            end
            ST_MERGE: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Broadcast operation to the row
    always_comb begin
        op.code = OP_NOP;
        op.idx = '0;
        op.size = size_ext;
        op.off = LW'(off_reg);
        op.count = count_reg;
        unique case (state_reg)
            ST_APPLY: begin
                if (cmd_reg == CMD_ALLOC) begin
                    op.idx = tok.best_idx;
                    if (alloc_ok) op.code = do_split ? OP_SPLIT : OP_TAKE;
                end else begin
                    op.idx = tok.midx;
                    if (tok.mfound) op.code = tok.rf ? OP_MERGE : OP_MARK;
                end
            end
            ST_MERGE: begin
                op.code = OP_MERGE;
                op.idx = k_reg - 1'b1;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            count_reg <= CW'(1);
            total_reg <= LW'(ARENA_BYTES - HEADER_BYTES);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Load a new result word, or drop the one just taken
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_APPLY: begin
                    if (cmd_reg == CMD_ALLOC) begin
                        if (alloc_ok) begin
                            if (do_split) begin
                                count_reg <= count_reg + 1'b1;
                                total_reg <= total_reg - size_ext - HDR;
                            end else begin
                                total_reg <= total_reg - tok.best_len;
                            end
                        end
                    end else if (tok.mfound) begin
                        // neighbors can only be free when the freed block was in use
                        total_reg <= total_reg + (tok.muse ? tok.mlen : '0)
                                     + (tok.rf ? HDR : '0) + (tok.lf ? HDR : '0);
                        if (tok.rf) count_reg <= count_reg - 1'b1;
                    end
                end
                ST_MERGE: begin
                    count_reg <= count_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload: request capture, result staging, output word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            size_reg <= s_tdata[14:0];
            off_reg <= s_tdata[29:15];
        end
        if (state_reg == ST_APPLY) begin
            k_reg <= tok.midx;
            lf_reg <= tok.lf;
            res_off_reg <= '0;
            if (cmd_reg == CMD_ALLOC) begin
                res_status_reg <= alloc_ok ? STATUS_OK : STATUS_NO_SPACE;
                if (alloc_ok) res_off_reg <= tok.best_start[FIELD_W-1:0];
            end else begin
                res_status_reg <= tok.mfound ? STATUS_OK : STATUS_NOT_FOUND;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_off_reg <= res_off_reg;
            m_free_reg <= total_reg[FIELD_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser = m_status_reg;
    assign m_tdata = {2'b00, m_free_reg, m_off_reg};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(1)) && (count_reg <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= LW'(ARENA_BYTES - HEADER_BYTES))
        else $error("free total exceeds arena");
    a_fail_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_status_reg != STATUS_OK) |-> (res_off_reg == '0))
        else $error("failed request carries an offset");
    a_merge_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> (lf_reg && k_reg != '0))
        else $error("left merge without free left neighbor");
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("scan did not start after accept");
`endif

endmodule
